// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and the binary-to-BCD step of the console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam logic [7:0] NEWLINE_CODE  = 8'd10;
	localparam logic [7:0] DIGIT_ZERO    = 8'd48;

	localparam int NUM_W         = 64;
	localparam int NUM_DIGITS    = 20;
	localparam int BCD_W         = NUM_DIGITS * 4;
	localparam int DIGIT_IDX_W   = 5;
	localparam int BITS_PER_STEP = 4;
	localparam int STEP_CNT_W    = 4;
	localparam int COL_W         = 7;
	localparam int ROW_W         = 5;
	localparam int IDX_W         = 11;
	localparam int WORD_W        = 16;

	typedef struct packed {
		logic load;
		logic newline;
		logic emit_char;
		logic conv_step;
		logic count;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic is_newline;
		logic conv_done;
		logic last_digit;
		logic out_free;
	} stat_t;

	// One double-dabble step: add 3 to every digit of 5 or more, then shift in b.
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
		input logic b);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], b};
	endfunction

endpackage

`default_nettype wire

// ----- src/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: accepts a transaction, runs conversion and steps cell writes.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          op,
	input  wire tcw_pkg::stat_t stat,
	output tcw_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHAR  = 3'd1;
	localparam logic [2:0] S_CONV  = 3'd2;
	localparam logic [2:0] S_COUNT = 3'd3;
	localparam logic [2:0] S_DIGIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = op ? S_CONV : S_CHAR;
				end
			end
			S_CHAR: begin
				if (stat.is_newline) begin
					cmd.newline = 1'b1;
					state_d     = S_IDLE;
				end else if (stat.out_free) begin
					cmd.emit_char = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_done) begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				state_d   = S_DIGIT;
			end
			S_DIGIT: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					if (stat.last_digit) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/tcw_dp.sv -----
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: cursor, decimal conversion, digit selection and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_dp #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tcw_pkg::cmd_t                 cmd,
	output tcw_pkg::stat_t                     stat,
	input  wire logic [7:0]                    char_code,
	input  wire logic [tcw_pkg::NUM_W-1:0]     number,
	input  wire logic [7:0]                    color,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [tcw_pkg::IDX_W-1:0]          cell_index,
	output logic [tcw_pkg::WORD_W-1:0]         cell_word,
	output logic                               last
);

	localparam int CW = tcw_pkg::COL_W;
	localparam int RW = tcw_pkg::ROW_W;
	localparam logic [CW-1:0] COLS_C     = CW'(COLUMNS);
	localparam logic [RW:0]   ROWS_C     = (RW + 1)'(ROWS);
	localparam logic [RW-1:0] LAST_ROW_C = RW'(ROWS - 1);
	localparam logic [tcw_pkg::STEP_CNT_W-1:0] LAST_STEP_C =
		tcw_pkg::STEP_CNT_W'(tcw_pkg::NUM_W / tcw_pkg::BITS_PER_STEP - 1);

	logic [CW-1:0]                      col_q;
	logic [RW-1:0]                      row_q;
	logic                               out_valid_q;
	logic [tcw_pkg::STEP_CNT_W-1:0]     step_q;
	logic [7:0]                         char_q;
	logic [7:0]                         color_q;
	logic [tcw_pkg::NUM_W-1:0]          bin_q;
	logic [tcw_pkg::BCD_W-1:0]          bcd_q;
	logic [tcw_pkg::DIGIT_IDX_W-1:0]    dig_q;
	logic [tcw_pkg::IDX_W-1:0]          idx_q;
	logic [tcw_pkg::WORD_W-1:0]         word_q;
	logic                               last_q;

	logic                               emit;
	logic [CW-1:0]                      col_w;
	logic [RW:0]                        row_wrap;
	logic [RW-1:0]                      row_w;
	logic [CW+RW-1:0]                   idx_full;
	logic [7:0]                         emit_char;
	logic [3:0]                         digit;
	logic [tcw_pkg::DIGIT_IDX_W-1:0]    top_digit;
	logic [tcw_pkg::BCD_W-1:0]          bcd_next;

	assign emit = cmd.emit_char | cmd.emit_digit;

	// Wrap and clamp the cursor ahead of a write.
	always_comb begin
		if (col_q >= COLS_C) begin
			col_w    = '0;
			row_wrap = {1'b0, row_q} + 1'b1;
		end else begin
			col_w    = col_q;
			row_wrap = {1'b0, row_q};
		end
		row_w    = (row_wrap >= ROWS_C) ? LAST_ROW_C : row_wrap[RW-1:0];
		idx_full = {{CW{1'b0}}, row_w} * {{RW{1'b0}}, COLS_C} + {{RW{1'b0}}, col_w};
	end

	assign digit     = bcd_q[dig_q*4 +: 4];
	assign emit_char = cmd.emit_digit ? (tcw_pkg::DIGIT_ZERO | {4'd0, digit}) : char_q;

	// Position of the most significant nonzero digit, zero for the value zero.
	always_comb begin
		top_digit = '0;
		for (int i = 0; i < tcw_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				top_digit = tcw_pkg::DIGIT_IDX_W'(i);
			end
		end
	end

	always_comb begin
		bcd_next = bcd_q;
		for (int s = 0; s < tcw_pkg::BITS_PER_STEP; s++) begin
			bcd_next = tcw_pkg::dabble_step(bcd_next, bin_q[tcw_pkg::NUM_W-1-s]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (cmd.newline) begin
				col_q <= '0;
				if ({1'b0, row_q} < ROWS_C) begin
					row_q <= row_q + 1'b1;
				end
			end else if (emit) begin
				col_q <= col_w + 1'b1;
				row_q <= row_w;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.conv_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q  <= char_code;
			color_q <= color;
			bin_q   <= number;
			bcd_q   <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= bcd_next;
			bin_q <= bin_q << tcw_pkg::BITS_PER_STEP;
		end
		if (cmd.count) begin
			dig_q <= top_digit;
		end else if (cmd.emit_digit) begin
			dig_q <= dig_q - 1'b1;
		end
		if (emit) begin
			idx_q  <= idx_full[tcw_pkg::IDX_W-1:0];
			word_q <= {color_q, emit_char};
			last_q <= cmd.emit_char | (dig_q == '0);
		end
	end

	assign stat.is_newline = (char_q == tcw_pkg::NEWLINE_CODE);
	assign stat.conv_done  = (step_q == LAST_STEP_C);
	assign stat.last_digit = (dig_q == '0);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign cell_index = idx_q;
	assign cell_word  = word_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// ----- src/text_console_cell_writer.sv -----
// Character path: after acceptance the sequencer waits in S_CHAR until the output
//   register is free, then loads the write and raises out_valid; a newline updates
//   the cursor from S_CHAR and writes nothing. Numbers of up to 20 digits:
//   the binary-to-decimal conversion takes 4 bits per cycle over 64 bits, then
//   one digit is written per cycle from the output register while it is free.
// Reset: asynchronous, clears the cursor to column 0, row 0, the sequencer and out_valid.
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console engine: places characters and decimal numbers as cell writes.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      op,
	input  wire logic [7:0]                char_code,
	input  wire logic [tcw_pkg::NUM_W-1:0] number,
	input  wire logic [7:0]                color,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [tcw_pkg::IDX_W-1:0]      cell_index,
	output logic [tcw_pkg::WORD_W-1:0]     cell_word,
	output logic                           last
);

	// Grid size; the cell index only stays in range when the grid fits 11 bits.
	localparam int CELLS = COLUMNS * ROWS;
	localparam logic FITS = (CELLS <= (1 << tcw_pkg::IDX_W));

	tcw_pkg::cmd_t  cmd;
	tcw_pkg::stat_t stat;

	// Sequencer: holds in_ready low from acceptance until the last cell write
	// of the transaction is in the output register, or a newline has moved the cursor.
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: captures the transaction, converts numbers, advances the cursor
	// and drives the output register that separates the two channels.
	tcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.char_code  (char_code),
		.number     (number),
		.color      (color),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_index (cell_index),
		.cell_word  (cell_word),
		.last       (last)
	);

	// Block busy in the cycle after any accepted transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after acceptance");

	// A newline returns to idle from S_CHAR without waiting on the output register.
	a_newline_returns: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !op && (char_code == tcw_pkg::NEWLINE_CODE)
		|-> ##2 in_ready)
		else $error("newline did not return to idle");

	// Cell index stays on the grid when the grid fits the index width.
	a_index_on_grid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && FITS |-> (int'(cell_index) < CELLS))
		else $error("cell index off the grid");

	// While idle, a cell write still pending in the output register is the final one of its transaction.
	a_no_new_input_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last)
		else $error("idle while a non-final cell write is pending");

endmodule

`default_nettype wire
